// ----- rtl/core/b64le_pkg.sv -----
// ----------------------------------------------------------------------------
// b64le_pkg
// Shared types and constants for the line-wrapped Base64 encoder.
// ----------------------------------------------------------------------------
package b64le_pkg;

  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One classified byte: up to four characters to send.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;  // index of the final character of this byte
    logic            msg_end;
  } entry_t;

  // Standard alphabet lookup.
  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'(v) + 8'd65;
    end else if (v < 6'd52) begin
      r = 8'(v) + 8'd71;   // 'a' - 26
    end else if (v < 6'd62) begin
      r = 8'(v) - 8'd4;    // '0' - 52
    end else if (v == 6'd62) begin
      r = 8'h2B;           // '+'
    end else begin
      r = 8'h2F;           // '/'
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/base64_line_wrapped_encoder.sv -----
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder
// Streaming Base64 encoder with CR LF after every LINE_CHARS/4 full groups.
// ----------------------------------------------------------------------------
// The first character of a byte passes through the queue and then the output register.
// The back end sends one character per cycle while the receiver takes them; a byte gives
//   1 to 4 characters, about 1.33 on average plus line breaks.
// The front takes a byte every cycle while the 4-entry queue has room.
// Reset (sync, active high) clears group phase, carry bits, line position,
//   the queue and the output valid.
module base64_line_wrapped_encoder #(
  parameter int LINE_CHARS = 76
) (
  input  logic       clk,
  input  logic       rst,
  // byte input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       message_end,
  // character output channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       run_last,
  output logic       encoded_end
);

  // Front -> queue word: characters for one byte, already classified.
  b64le_pkg::entry_t q_entry;
  b64le_pkg::entry_t q_head;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;

  // Front: tracks phase / carry / line position, builds the character list.
  b64le_front #(
    .LINE_CHARS (LINE_CHARS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .message_end (message_end),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  // Decoupling queue so input and output stall independently.
  b64le_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // Back: serializes characters into the registered output.
  b64le_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .empty       (q_empty),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .run_last    (run_last),
    .encoded_end (encoded_end)
  );

endmodule

// ----- rtl/core/b64le_front.sv -----
// ----------------------------------------------------------------------------
// b64le_front
// Takes bytes, tracks group phase and line position, classifies each byte
// into the characters it produces.
// ----------------------------------------------------------------------------
module b64le_front #(
  parameter int LINE_CHARS = 76
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                message_end,
  input  logic                q_full,
  output logic                q_push,
  output b64le_pkg::entry_t   q_entry
);

  localparam int GPL = LINE_CHARS / 4;
  localparam int GW  = $clog2(GPL + 1);

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;

  logic [1:0]    phase, phase_next;
  logic [3:0]    carry, carry_next;
  logic [GW-1:0] groups, groups_next;
  logic          wrap;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign wrap     = (groups == GW'(GPL - 1));

  always_comb begin
    q_entry          = '0;
    q_entry.msg_end  = message_end;
    phase_next       = phase;
    carry_next       = carry;
    groups_next      = groups;
    unique case (phase)
      PH_1: begin
        q_entry.chars[0] = b64le_pkg::b64_sym({carry[1:0], data_byte[7:4]});
        carry_next       = data_byte[3:0];
        phase_next       = PH_2;
        if (message_end) begin
          q_entry.chars[1] = b64le_pkg::b64_sym({data_byte[3:0], 2'b00});
          q_entry.chars[2] = b64le_pkg::CHAR_PAD;
          q_entry.last_idx = 2'd2;
        end
      end
      PH_2: begin
        q_entry.chars[0] = b64le_pkg::b64_sym({carry, data_byte[7:6]});
        q_entry.chars[1] = b64le_pkg::b64_sym(data_byte[5:0]);
        q_entry.last_idx = 2'd1;
        carry_next       = 4'd0;
        phase_next       = PH_0;
        if (wrap) begin
          q_entry.chars[2] = b64le_pkg::CHAR_CR;
          q_entry.chars[3] = b64le_pkg::CHAR_LF;
          q_entry.last_idx = 2'd3;
          groups_next      = '0;
        end else begin
          groups_next      = groups + GW'(1);
        end
      end
      default: begin  // phase 0 (and the unused code)
        q_entry.chars[0] = b64le_pkg::b64_sym(data_byte[7:2]);
        carry_next       = {2'b00, data_byte[1:0]};
        phase_next       = PH_1;
        if (message_end) begin
          q_entry.chars[1] = b64le_pkg::b64_sym({data_byte[1:0], 4'b0000});
          q_entry.chars[2] = b64le_pkg::CHAR_PAD;
          q_entry.chars[3] = b64le_pkg::CHAR_PAD;
          q_entry.last_idx = 2'd3;
        end
      end
    endcase
    if (message_end) begin
      phase_next  = PH_0;
      carry_next  = 4'd0;
      groups_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_0;
      carry  <= 4'd0;
      groups <= '0;
    end else if (q_push) begin
      phase  <= phase_next;
      carry  <= carry_next;
      groups <= groups_next;
    end
  end

`ifndef ASSERT_OFF
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    q_push && message_end |=> phase == PH_0 && groups == '0 && carry == 4'd0)
    else $error("state not cleared after message end");
  a_line_bound: assert property (@(posedge clk) disable iff (rst)
    groups < GW'(GPL))
    else $error("line group count out of range");
`endif

endmodule

// ----- rtl/core/b64le_fifo.sv -----
// ----------------------------------------------------------------------------
// b64le_fifo
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module b64le_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64le_pkg::entry_t push_entry,
  input  logic              pop,
  output b64le_pkg::entry_t head,
  output logic              full,
  output logic              empty
);

  localparam int AW = b64le_pkg::QUEUE_AW;

  b64le_pkg::entry_t mem [b64le_pkg::QUEUE_DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;

  assign full  = (count == (AW + 1)'(b64le_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW + 1)'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/core/b64le_back.sv -----
// ----------------------------------------------------------------------------
// b64le_back
// Walks the head entry into the output register one character per cycle while that register is free or taken.
// ----------------------------------------------------------------------------
module b64le_back (
  input  logic              clk,
  input  logic              rst,
  input  b64le_pkg::entry_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              run_last,
  output logic              encoded_end
);

  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = !empty && (!out_valid || out_ready);
  assign at_last = (idx == head.last_idx);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char    <= head.chars[idx];
      run_last    <= at_last;
      encoded_end <= at_last && head.msg_end;
    end
  end

`ifndef ASSERT_OFF
  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && encoded_end |-> run_last)
    else $error("encoded_end without run_last");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> idx <= head.last_idx)
    else $error("character index past end of entry");
`endif

endmodule

// ----- test/b64le_char_checker.sv -----
// ----------------------------------------------------------------------------
// b64le_char_checker
// Watches both channels of the line-wrapped Base64 encoder, predicts the
// character stream for every accepted byte and compares each output word.
// ----------------------------------------------------------------------------
module b64le_char_checker #(
  parameter int LINE_CHARS = 76
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       message_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_char,
  input  logic       run_last,
  input  logic       encoded_end,
  output int         fail_count,
  output int         pending,
  output int         char_count,
  output int         break_count
);

  localparam int GROUPS_PER_LINE = LINE_CHARS / 4;
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       enc_end;
  } char_word_t;

  char_word_t expected_chars[$];
  char_word_t want;

  // encoder state as the predictor sees it
  logic [1:0] grp_phase;
  logic [3:0] carry;
  int         line_groups;

  int errors;
  int n_chars;
  int n_breaks;

  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    return ALPHABET[8*(63 - int'(v)) +: 8];
  endfunction

  // Expected characters for one accepted byte.
  function automatic void encode_byte(input logic [7:0] b, input logic last);
    logic [7:0] chars[4];
    int         n;
    char_word_t w;
    n = 0;
    case (grp_phase)
      2'd1: begin
        chars[0] = alpha_char({carry[1:0], b[7:4]});
        n = 1;
        carry = b[3:0];
        grp_phase = 2'd2;
        if (last) begin
          chars[1] = alpha_char({b[3:0], 2'b00});
          chars[2] = b64le_pkg::CHAR_PAD;
          n = 3;
        end
      end
      2'd2: begin
        chars[0] = alpha_char({carry, b[7:6]});
        chars[1] = alpha_char(b[5:0]);
        n = 2;
        carry = 4'd0;
        grp_phase = 2'd0;
        line_groups++;
        // break also when this group closes the message
        if (line_groups >= GROUPS_PER_LINE) begin
          chars[2] = b64le_pkg::CHAR_CR;
          chars[3] = b64le_pkg::CHAR_LF;
          n = 4;
          line_groups = 0;
        end
      end
      default: begin  // phase 3 never happens, treated as 0
        chars[0] = alpha_char(b[7:2]);
        n = 1;
        carry = {2'b00, b[1:0]};
        grp_phase = 2'd1;
        if (last) begin
          chars[1] = alpha_char({b[1:0], 4'b0000});
          chars[2] = b64le_pkg::CHAR_PAD;
          chars[3] = b64le_pkg::CHAR_PAD;
          n = 4;
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      w.ch       = chars[i];
      w.run_last = (i == n - 1);
      w.enc_end  = (i == n - 1) && last;
      expected_chars.push_back(w);
    end
    if (last) begin
      grp_phase   = 2'd0;
      carry       = 4'd0;
      line_groups = 0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_chars.delete();
      grp_phase   = 2'd0;
      carry       = 4'd0;
      line_groups = 0;
      errors      = 0;
      n_chars     = 0;
      n_breaks    = 0;
    end else begin
      // outputs first: a byte's characters never appear on its own edge
      if (out_valid && out_ready) begin
        n_chars++;
        if (out_char == b64le_pkg::CHAR_CR) begin
          n_breaks++;
        end
        if (expected_chars.size() == 0) begin
          if (errors < 10) begin
            $display("[%0t] unexpected word: char %02h run_last %0b end %0b",
                     $time, out_char, run_last, encoded_end);
          end
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch || run_last !== want.run_last ||
              encoded_end !== want.enc_end) begin
            if (errors < 10) begin
              $display("[%0t] mismatch: exp char %02h run_last %0b end %0b, got %02h %0b %0b",
                       $time, want.ch, want.run_last, want.enc_end,
                       out_char, run_last, encoded_end);
            end
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        encode_byte(data_byte, message_end);
      end
    end
    fail_count  <= errors;
    pending     <= expected_chars.size();
    char_count  <= n_chars;
    break_count <= n_breaks;
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives byte messages into the line-wrapped Base64 encoder under four idle
// and stall mixes; a side checker predicts and compares every character.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LINE_CHARS  = 76;
  localparam int CYCLE_LIMIT = 200000;  // far above the slowest correct run
  localparam int PHASE_BYTES = 10;      // least number of random bytes per idle mix

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       message_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       encoded_end;

  int fail_count;
  int pending;
  int char_count;
  int break_count;

  int send_idle_pct;   // chance per cycle that the sender holds off
  int recv_stall_pct;  // chance per cycle that the receiver drops ready
  int cycles;
  int bytes_sent;
  int messages_sent;

  base64_line_wrapped_encoder #(
    .LINE_CHARS(LINE_CHARS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .message_end(message_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .run_last   (run_last),
    .encoded_end(encoded_end)
  );

  b64le_char_checker #(
    .LINE_CHARS(LINE_CHARS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .message_end(message_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .run_last   (run_last),
    .encoded_end(encoded_end),
    .fail_count (fail_count),
    .pending    (pending),
    .char_count (char_count),
    .break_count(break_count)
  );

  // 10-unit clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: ready is redrawn every falling edge from the current stall rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a hang or a lost character ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d characters still owed", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one byte word and hold it until taken. Entered and left at a
  // falling edge; valid is never dropped here unless an idle gap follows,
  // so back-to-back words keep valid high with a single update.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    message_end <= last;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
    bytes_sent++;
    if (last) begin
      messages_sent++;
    end
  endtask

  // Well-formed message of random content; the flag sits on the last byte.
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // Mostly short messages, some long enough to wrap, with the lengths
  // around one full line (55..59) favored to hit the break boundary.
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      return $urandom_range(5, 1);
    end else if (r < 80) begin
      return $urandom_range(20, 6);
    end
    return $urandom_range(59, 55);
  endfunction

  initial begin
    int phase_bytes;
    int len;
    rst            = 1'b1;
    in_valid       = 1'b0;
    data_byte      = 8'h00;
    message_end    = 1'b0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycles         = 0;
    bytes_sent     = 0;
    messages_sent  = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: one- and two-byte tails with both pad forms, all-zero and
    // all-one bytes, a full group that ends the message, and mixed masks.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h3F, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFC, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h3F, 1'b1);
    // one group plus a partial one: the partial must not count on the line
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b1);

    // Random part, one idle mix per phase.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      phase_bytes = 0;
      // exactly one line, so the break lands on the closing group
      if (ph == 0 || ph == 2) begin
        send_message(57);
        phase_bytes += 57;
      end
      while (phase_bytes < PHASE_BYTES) begin
        len = pick_length();
        send_message(len);
        phase_bytes += len;
      end
    end
    in_valid <= 1'b0;

    // Drain, then a short tail to catch stray words.
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d messages; got %0d characters with %0d line breaks",
             bytes_sent, messages_sent, char_count, break_count);
    $display("Idle mixes: none, sender 80%%, receiver 80%%, both 26%%");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/b64le_pkg.sv
rtl/core/b64le_front.sv
rtl/core/b64le_fifo.sv
rtl/core/b64le_back.sv
rtl/core/base64_line_wrapped_encoder.sv
test/b64le_char_checker.sv
test/tb_top.sv
